// ----- rtl/oia_pkg.sv -----
// Shared constants, codes and types of the ordered integer array engine.
`default_nettype none

package oia_pkg;

   // Fixed capacity of the entry store.
   localparam int CAPACITY = 256;

   // Widths of the request and response fields.
   localparam int OpW    = 4;
   localparam int PosW   = 9;
   localparam int ValW   = 32;
   localparam int LenW   = 9;
   localparam int StatW  = 2;

   // Store addressing and entry counting.
   localparam int AddrW  = $clog2(CAPACITY);
   localparam int CntW   = $clog2(CAPACITY + 1);
   // Common width for comparing a position against the count, with a spare bit.
   localparam int CmpW   = ((CntW > PosW) ? CntW : PosW) + 1;

   // Packed stream payloads, padded to whole bytes.
   localparam int ReqUsedW  = OpW + PosW + ValW;
   localparam int ReqDataW  = ((ReqUsedW + 7) / 8) * 8;
   localparam int RspUsedW  = ValW + 1 + LenW + StatW;
   localparam int RspDataW  = ((RspUsedW + 7) / 8) * 8;
   localparam int RspPadW   = RspDataW - RspUsedW;

   typedef enum logic [OpW-1:0] {
      OP_APPEND = 4'd0,
      OP_INSERT = 4'd1,
      OP_DELETE = 4'd2,
      OP_GET    = 4'd3,
      OP_SET    = 4'd4,
      OP_POP    = 4'd5,
      OP_PEEK   = 4'd6,
      OP_SEARCH = 4'd7,
      OP_CLEAR  = 4'd8
   } opcode_type;

   typedef enum logic [StatW-1:0] {
      ST_OK     = 2'd0,
      ST_BOUNDS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // One write port and one read port of the entry store, driven each cycle.
   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [ValW-1:0]  wdata;
      logic [AddrW-1:0] raddr;
   } mem_req_type;

endpackage

`default_nettype wire

// ----- rtl/oia_store.sv -----
// Entry store: one write port and one registered read port.
`default_nettype none

module oia_store
   import oia_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output logic [ValW-1:0]  rd_data
);

   logic [ValW-1:0] mem [CAPACITY];
   logic [ValW-1:0] rd_data_ff;

   // Write the addressed entry; register the read every cycle.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/ordered_int_array_engine_unit.sv -----
// Top level of the ordered integer array engine: request decode, sequencer, response register.
//
// Usage:
//  - Requests enter on req_* (tvalid/tready/tdata); each names one operation on an ordered
//    array of signed 32-bit entries: append, insert, delete, get, set, pop, peek, search, clear.
//  - Every request yields exactly one response on rsp_*: read value, found flag, length after
//    the request and a status (ok, index out of bounds, empty, full).
//  - The block works on one request at a time; req_tready is high only while it is idle.
//  - Append, set, pop, clear, errors and unused opcodes go straight to the finish state; get
//    and peek read one entry first; insert at p below the length, delete below the last entry
//    and a search of a non-empty array walk the store, and insert then places the new value.
//  - The walk is set by the single store read port: one entry moved or compared per cycle.
//  - A new request is taken while the previous response still waits in the response
//    register; the finished result of that request then holds until rsp_tready frees it.
//  - Synchronous active-high reset empties the array (length 0) and drops any pending
//    response; store contents are not cleared and need no clearing pass.
`default_nettype none

module ordered_int_array_engine_unit
   import oia_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // req_tdata: opcode[3:0], position[12:4], operand_value[44:13], zero pad[47:45]
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,
   // rsp_tdata: read_value[31:0], found[32], current_length[41:33], status[43:42], pad[47:44]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspDataW-1:0]      rsp_tdata
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ACT    = 4'b0010,
      S_PLACE  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   opcode_type              op_ff, op_in;
   logic [PosW-1:0]         pos_ff, pos_in;
   logic [ValW-1:0]         val_ff, val_in;
   logic [CntW-1:0]         idx_ff, idx_in;
   logic [CntW-1:0]         count_ff, count_in;
   status_type              status_ff, status_in;
   logic [ValW-1:0]         rd_ff, rd_in;
   logic                    found_ff, found_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]     rsp_data_ff, rsp_data_in;

   mem_req_type             mem_req;
   logic [ValW-1:0]         mem_rdata;

   // Request fields.
   opcode_type              req_op;
   logic [PosW-1:0]         req_pos;
   logic [ValW-1:0]         req_val;
   logic [CmpW-1:0]         req_pos_ext;
   logic [CmpW-1:0]         count_ext;
   logic                    is_full;
   logic                    is_empty;

   assign req_op      = opcode_type'(req_tdata[OpW-1:0]);
   assign req_pos     = req_tdata[OpW +: PosW];
   assign req_val     = req_tdata[OpW+PosW +: ValW];
   assign req_pos_ext = CmpW'(req_pos);
   assign count_ext   = CmpW'(count_ff);
   assign is_full     = (count_ff >= CntW'(CAPACITY));
   assign is_empty    = (count_ff == '0);

   assign req_tready  = (state_ff == S_IDLE);

   oia_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;

      // Drop the response once the receiver takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_op;
               pos_in    = req_pos;
               val_in    = req_val;
               status_in = ST_OK;
               rd_in     = '0;
               found_in  = 1'b0;
               state_in  = S_FINISH;
               unique case (req_op)
                  OP_APPEND: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = AddrW'(count_ff);
                        mem_req.wdata = req_val;
                        count_in      = count_ff + CntW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (req_pos_ext > count_ext) begin
                        status_in = ST_BOUNDS;
                     end else if (is_full) begin
                        status_in = ST_FULL;
                     end else if (req_pos_ext == count_ext) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = AddrW'(count_ff);
                        mem_req.wdata = req_val;
                        count_in      = count_ff + CntW'(1);
                     end else begin
                        // Walk down from the end, moving each entry up by one.
                        idx_in        = count_ff;
                        mem_req.raddr = AddrW'(count_ff - CntW'(1));
                        state_in      = S_ACT;
                     end
                  end
                  OP_DELETE: begin
                     if (req_pos_ext >= count_ext) begin
                        status_in = ST_BOUNDS;
                     end else if (req_pos_ext + CmpW'(1) >= count_ext) begin
                        count_in = count_ff - CntW'(1);
                     end else begin
                        // Walk up from the hole, moving each entry down by one.
                        idx_in        = CntW'(req_pos);
                        mem_req.raddr = AddrW'(req_pos_ext + CmpW'(1));
                        state_in      = S_ACT;
                     end
                  end
                  OP_GET: begin
                     if (req_pos_ext >= count_ext) begin
                        status_in = ST_BOUNDS;
                     end else begin
                        mem_req.raddr = AddrW'(req_pos);
                        state_in      = S_ACT;
                     end
                  end
                  OP_SET: begin
                     if (req_pos_ext >= count_ext) begin
                        status_in = ST_BOUNDS;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = AddrW'(req_pos);
                        mem_req.wdata = req_val;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CntW'(1);
                     end
                  end
                  OP_PEEK: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_req.raddr = AddrW'(count_ff - CntW'(1));
                        state_in      = S_ACT;
                     end
                  end
                  OP_SEARCH: begin
                     if (!is_empty) begin
                        idx_in        = '0;
                        mem_req.raddr = '0;
                        state_in      = S_ACT;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_ACT: begin
            unique case (op_ff)
               OP_INSERT: begin
                  // Move the entry below idx up into idx.
                  mem_req.we    = 1'b1;
                  mem_req.waddr = AddrW'(idx_ff);
                  mem_req.wdata = mem_rdata;
                  idx_in        = idx_ff - CntW'(1);
                  if (CmpW'(idx_ff) == CmpW'(pos_ff) + CmpW'(1)) begin
                     state_in = S_PLACE;
                  end else begin
                     mem_req.raddr = AddrW'(idx_ff - CntW'(2));
                  end
               end
               OP_DELETE: begin
                  // Move the entry above idx down into idx.
                  mem_req.we    = 1'b1;
                  mem_req.waddr = AddrW'(idx_ff);
                  mem_req.wdata = mem_rdata;
                  idx_in        = idx_ff + CntW'(1);
                  if (CmpW'(idx_ff) + CmpW'(2) < count_ext) begin
                     mem_req.raddr = AddrW'(CmpW'(idx_ff) + CmpW'(2));
                  end else begin
                     count_in = count_ff - CntW'(1);
                     state_in = S_FINISH;
                  end
               end
               OP_GET, OP_PEEK: begin
                  rd_in    = mem_rdata;
                  state_in = S_FINISH;
               end
               OP_SEARCH: begin
                  if (mem_rdata == val_ff) begin
                     found_in = 1'b1;
                     state_in = S_FINISH;
                  end else if (CmpW'(idx_ff) + CmpW'(1) < count_ext) begin
                     idx_in        = idx_ff + CntW'(1);
                     mem_req.raddr = AddrW'(CmpW'(idx_ff) + CmpW'(1));
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         S_PLACE: begin
            // Drop the new value into the opened slot.
            mem_req.we    = 1'b1;
            mem_req.waddr = AddrW'(pos_ff);
            mem_req.wdata = val_ff;
            count_in      = count_ff + CntW'(1);
            state_in      = S_FINISH;
         end

         S_FINISH: begin
            // Hold the result until the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {RspPadW'(0), status_ff, LenW'(count_ff), found_ff, rd_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The length never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("entry count above capacity");

   // A new response is only loaded out of the finish state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   // An insert walk always stays above the target slot.
   a_insert_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACT && op_ff == OP_INSERT) |-> (CmpW'(idx_ff) > CmpW'(pos_ff)))
      else $error("insert walk passed its target");

   // The length holds while a finished result waits.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> $stable(count_ff))
      else $error("count changed after the operation finished");

   // The store is written only while an operation is being started or walked.
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (state_ff != S_FINISH))
      else $error("store written while waiting on the response");
`endif

endmodule

`default_nettype wire
